[hw/rtl/marker_length_frame_parser_defines.svh]
// Assertion macros for the marker/length frame parser RTL, used by mlfp_parser.
`ifndef MARKER_LENGTH_FRAME_PARSER_DEFINES_SVH
`define MARKER_LENGTH_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mlfp assertion failed");

// Next-cycle implication, checked outside reset.
`define MLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mlfp assertion failed");

`endif

[hw/rtl/mlfp_pkg.sv]
// Types and constants shared by the marker/length frame parser.
`timescale 1ns / 1ps

package mlfp_pkg;

    localparam int MAX_FRAME = 4096;
    localparam int LEN_W     = 13;
    localparam int BLEN_W    = 12;
    localparam int WORD_W    = 32;
    localparam int OVERHEAD  = 12;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 13'd4096;
    localparam logic [WORD_W-1:0] START_RESET   = 32'hDEADBEEF;
    localparam logic [WORD_W-1:0] END_RESET     = 32'hBEEFDEAD;

    typedef enum logic [1:0] {
        CFG_MAX_LEN = 2'd0,
        CFG_START   = 2'd1,
        CFG_END     = 2'd2,
        CFG_UNUSED  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_END    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        KIND_BODY      = 3'd0,
        KIND_GOOD      = 3'd1,
        KIND_BAD_START = 3'd2,
        KIND_BAD_LEN   = 3'd3,
        KIND_BAD_END   = 3'd4
    } t_kind;

    typedef struct packed {
        logic [LEN_W-1:0]  max_len;
        logic [WORD_W-1:0] sof_word;
        logic [WORD_W-1:0] eof_word;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_beat;

endpackage

[hw/rtl/mlfp_if.sv]
// Valid/ready stream interfaces for the received bytes and the parser results.
`timescale 1ns / 1ps

interface mlfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [11:0] payload_len;
    logic [31:0] frame_count;

    modport source (output valid, output kind, output body_byte, output body_last,
                    output payload_len, output frame_count, input ready);
    modport sink   (input valid, input kind, input body_byte, input body_last,
                    input payload_len, input frame_count, output ready);
endinterface

[hw/rtl/marker_length_frame_parser.sv]
// Path: each byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the result register stalls intake only while it is full
// and the sink holds ready low. Phase, counters and checks update once per accepted byte.
// Reset (synchronous, active low): hunt for a start marker, good-frame count zero,
// configuration registers back to 4096, 0xDEADBEEF and 0xBEEFDEAD.
`timescale 1ns / 1ps

module marker_length_frame_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mlfp_in_if.sink                     i_in,
    mlfp_out_if.source                  o_out,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [mlfp_pkg::WORD_W-1:0] i_cfg_data
);

    mlfp_pkg::t_cfg  cfg;
    mlfp_pkg::t_beat beat;
    logic            adv;

    mlfp_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mlfp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_beat  (beat)
    );

    mlfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_beat  (beat),
        .o_adv   (adv),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/mlfp_cfg_regs.sv]
// Configuration registers: maximum frame length, start and end markers.
`timescale 1ns / 1ps

module mlfp_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [mlfp_pkg::WORD_W-1:0] i_cfg_data,
    output mlfp_pkg::t_cfg              o_cfg
);

    mlfp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len  <= mlfp_pkg::MAX_LEN_RESET;
            r_cfg.sof_word <= mlfp_pkg::START_RESET;
            r_cfg.eof_word <= mlfp_pkg::END_RESET;
        end else if (i_cfg_we) begin
            unique case (mlfp_pkg::t_cfg_idx'(i_cfg_idx))
                mlfp_pkg::CFG_MAX_LEN: begin
                    r_cfg.max_len <= i_cfg_data[mlfp_pkg::LEN_W-1:0];
                end
                mlfp_pkg::CFG_START: begin
                    r_cfg.sof_word <= i_cfg_data;
                end
                mlfp_pkg::CFG_END: begin
                    r_cfg.eof_word <= i_cfg_data;
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/mlfp_in_reg.sv]
// Input register stage: captures one received byte per beat.
`timescale 1ns / 1ps

module mlfp_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mlfp_in_if.sink         i_in,
    input  logic            i_adv,
    output mlfp_pkg::t_beat o_beat
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       n_valid;

    // take a new beat when empty or when the held byte moves on this cycle
    assign i_in.ready = !r_valid || i_adv;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data <= i_in.rx_byte;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.data  = r_data;

endmodule

[hw/rtl/mlfp_parser.sv]
// Frame parser: phase tracking, marker and length checks, result register.
`timescale 1ns / 1ps
`include "marker_length_frame_parser_defines.svh"

module mlfp_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mlfp_pkg::t_cfg  i_cfg,
    input  mlfp_pkg::t_beat i_beat,
    output logic            o_adv,
    mlfp_out_if.source      o_out
);

    mlfp_pkg::t_phase                    r_phase, n_phase;
    logic [mlfp_pkg::BLEN_W-1:0]         r_cnt, n_cnt;
    logic [23:0]                         r_shift;
    logic [mlfp_pkg::LEN_W-1:0]          r_total, n_total;
    logic [mlfp_pkg::WORD_W-1:0]         r_good, n_good;

    logic                                r_out_valid, n_out_valid;
    mlfp_pkg::t_kind                     r_kind, n_kind;
    logic [7:0]                          r_byte, n_byte;
    logic                                r_last, n_last;
    logic [mlfp_pkg::BLEN_W-1:0]         r_blen, n_blen;
    logic [mlfp_pkg::WORD_W-1:0]         r_count;

    logic                                has_res;
    logic                                load;
    logic                                word_done;
    logic [mlfp_pkg::WORD_W-1:0]         word;
    logic [mlfp_pkg::LEN_W-1:0]          limit;
    logic [mlfp_pkg::LEN_W-1:0]          total_diff;
    logic [mlfp_pkg::BLEN_W-1:0]         blen;

    assign o_adv      = i_beat.valid && (!r_out_valid || o_out.ready);
    assign load       = o_adv && has_res;
    assign word       = {r_shift, i_beat.data};
    assign word_done  = (r_cnt[1:0] == 2'd3);
    assign total_diff = r_total - mlfp_pkg::LEN_W'(mlfp_pkg::OVERHEAD);
    assign blen       = total_diff[mlfp_pkg::BLEN_W-1:0];
    assign limit      = (i_cfg.max_len > mlfp_pkg::LEN_W'(mlfp_pkg::MAX_FRAME))
                      ? mlfp_pkg::LEN_W'(mlfp_pkg::MAX_FRAME) : i_cfg.max_len;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_total = r_total;
        n_good  = r_good;
        has_res = 1'b0;
        n_kind  = mlfp_pkg::KIND_BODY;
        n_byte  = 8'd0;
        n_last  = 1'b0;
        n_blen  = '0;
        unique case (r_phase)
            mlfp_pkg::PH_START: begin
                n_cnt = r_cnt + 1'b1;
                if (word_done) begin
                    n_cnt = '0;
                    if (word != i_cfg.sof_word) begin
                        has_res = 1'b1;
                        n_kind  = mlfp_pkg::KIND_BAD_START;
                    end else begin
                        n_phase = mlfp_pkg::PH_LENGTH;
                    end
                end
            end
            mlfp_pkg::PH_LENGTH: begin
                n_cnt = r_cnt + 1'b1;
                if (word_done) begin
                    n_cnt = '0;
                    if (word < mlfp_pkg::WORD_W'(mlfp_pkg::OVERHEAD) ||
                        word > mlfp_pkg::WORD_W'(limit)) begin
                        has_res = 1'b1;
                        n_kind  = mlfp_pkg::KIND_BAD_LEN;
                        n_phase = mlfp_pkg::PH_START;
                    end else begin
                        n_total = word[mlfp_pkg::LEN_W-1:0];
                        n_phase = (word[mlfp_pkg::LEN_W-1:0] ==
                                   mlfp_pkg::LEN_W'(mlfp_pkg::OVERHEAD))
                                ? mlfp_pkg::PH_END : mlfp_pkg::PH_BODY;
                    end
                end
            end
            mlfp_pkg::PH_BODY: begin
                has_res = 1'b1;
                n_byte  = i_beat.data;
                n_blen  = blen;
                if ({1'b0, r_cnt} + 1'b1 >= {1'b0, blen}) begin
                    n_last  = 1'b1;
                    n_cnt   = '0;
                    n_phase = mlfp_pkg::PH_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            mlfp_pkg::PH_END: begin
                n_cnt = r_cnt + 1'b1;
                if (word_done) begin
                    has_res = 1'b1;
                    n_blen  = blen;
                    n_cnt   = '0;
                    n_phase = mlfp_pkg::PH_START;
                    if (word == i_cfg.eof_word) begin
                        n_kind = mlfp_pkg::KIND_GOOD;
                        n_good = r_good + 1'b1;
                    end else begin
                        n_kind = mlfp_pkg::KIND_BAD_END;
                    end
                end
            end
            default: begin
                n_phase = mlfp_pkg::PH_START;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mlfp_pkg::PH_START;
            r_cnt       <= '0;
            r_total     <= '0;
            r_good      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_adv) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_total <= n_total;
                r_good  <= n_good;
            end
        end
    end

    // shift history only matters within one four-byte word
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_shift <= word[23:0];
        end
        if (load) begin
            r_kind  <= n_kind;
            r_byte  <= n_byte;
            r_last  <= n_last;
            r_blen  <= n_blen;
            r_count <= r_good;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.body_byte   = r_byte;
    assign o_out.body_last   = r_last;
    assign o_out.payload_len = r_blen;
    assign o_out.frame_count = r_count;

    `MLFP_ASSERT_NOW(a_ctrl_only_no_data, i_clk, i_rst_n,
        r_out_valid && (r_kind != mlfp_pkg::KIND_BODY), (r_byte == 8'd0) && !r_last)
    `MLFP_ASSERT_NEXT(a_last_enters_end, i_clk, i_rst_n,
        load && n_last, r_phase == mlfp_pkg::PH_END)
    `MLFP_ASSERT_NOW(a_body_in_range, i_clk, i_rst_n,
        r_phase == mlfp_pkg::PH_BODY,
        (r_total > mlfp_pkg::LEN_W'(mlfp_pkg::OVERHEAD)) && (r_cnt < blen))
    `MLFP_ASSERT_NEXT(a_good_counts, i_clk, i_rst_n,
        load && (n_kind == mlfp_pkg::KIND_GOOD), r_good == $past(r_good) + 1'b1)

endmodule
